[hw/rtl/unique_key_sequential_table_assert.svh]
// Assertion macros for the unique key table.
// Included by the top level; needs no package.
`ifndef UNIQUE_KEY_SEQUENTIAL_TABLE_ASSERT_SVH
`define UNIQUE_KEY_SEQUENTIAL_TABLE_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define UKTAB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masks the check.
`define UKTAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/uktab_pkg.sv]
// Shared types, widths and codes of the unique key table.
// No dependencies; compile first.
package uktab_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = 7;
   localparam int KEY_W   = 16;
   localparam int AGE_W   = 8;
   localparam int ENTRY_W = KEY_W + AGE_W;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      KIND_INSERT      = 2'd0,
      KIND_REMOVE_KEY  = 2'd1,
      KIND_REMOVE_LAST = 2'd2,
      KIND_FILTER      = 2'd3
   } uktab_kind_type;

   typedef enum logic [2:0] {
      STAT_ADDED    = 3'd0,
      STAT_DUP      = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_REMOVED  = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_MATCH    = 3'd5,
      STAT_NOMATCH  = 3'd6
   } uktab_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESULT
   } uktab_state_type;

   typedef struct packed {
      uktab_status_type   status;
      logic [KEY_W-1:0]   out_key;
      logic [AGE_W-1:0]   out_age;
      logic               last_item;
      logic [CNT_W-1:0]   entry_total;
   } uktab_result_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } uktab_ram_wr_type;

endpackage

[hw/rtl/uktab_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on uktab_pkg.
interface uktab_req_if;
   logic                          valid;
   logic                          ready;
   uktab_pkg::uktab_kind_type     kind;
   logic [uktab_pkg::KEY_W-1:0]   game_key;
   logic [uktab_pkg::AGE_W-1:0]   age_value;
   logic [uktab_pkg::AGE_W-1:0]   min_age;

   modport source (output valid, kind, game_key, age_value, min_age, input ready);
   modport sink   (input valid, kind, game_key, age_value, min_age, output ready);
endinterface

interface uktab_rsp_if;
   logic                          valid;
   logic                          ready;
   uktab_pkg::uktab_status_type   status;
   logic [uktab_pkg::KEY_W-1:0]   out_key;
   logic [uktab_pkg::AGE_W-1:0]   out_age;
   logic                          last_item;
   logic [uktab_pkg::CNT_W-1:0]   entry_total;

   modport source (output valid, status, out_key, out_age, last_item, entry_total,
                   input ready);
   modport sink   (input valid, status, out_key, out_age, last_item, entry_total,
                   output ready);
endinterface

[hw/rtl/uktab_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module uktab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/uktab_engine.sv]
// Sequencer of the unique key table: scan, compaction shift and filter over the entry RAM.
// Depends on uktab_pkg and uktab_if.
module uktab_engine (
   input  logic                              clock,
   input  logic                              reset,
   uktab_req_if.sink                         req_ch,
   output logic                              res_valid,
   input  logic                              res_ready,
   output uktab_pkg::uktab_result_type       res,
   output uktab_pkg::uktab_ram_wr_type       ram_wr,
   output logic [uktab_pkg::ADDR_W-1:0]      ram_raddr,
   input  logic [uktab_pkg::ENTRY_W-1:0]     ram_rdata
);
   import uktab_pkg::*;

   uktab_state_type  state_ff, state_in;
   uktab_kind_type   op_ff, op_in;
   uktab_status_type status_ff, status_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic [AGE_W-1:0] min_ff, min_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [KEY_W-1:0] pend_key_ff, pend_key_in;
   logic [AGE_W-1:0] pend_age_ff, pend_age_in;

   logic [KEY_W-1:0] rd_key;
   logic [AGE_W-1:0] rd_age;
   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] idx_prev;
   logic             more;
   logic             key_hit;
   logic             age_hit;

   assign rd_key   = ram_rdata[ENTRY_W-1:AGE_W];
   assign rd_age   = ram_rdata[AGE_W-1:0];
   assign idx_next = idx_ff + 1'b1;
   assign idx_prev = idx_ff - 1'b1;
   assign more     = idx_ff < fill_ff;
   assign key_hit  = rd_key == key_ff;
   assign age_hit  = rd_age >= min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         idx_ff      <= '0;
         pend_vld_ff <= 1'b0;
         op_ff       <= KIND_INSERT;
         status_ff   <= STAT_ADDED;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         pend_vld_ff <= pend_vld_in;
         op_ff       <= op_in;
         status_ff   <= status_in;
      end
      key_ff      <= key_in;
      age_ff      <= age_in;
      min_ff      <= min_in;
      pend_key_ff <= pend_key_in;
      pend_age_ff <= pend_age_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      key_in       = key_ff;
      age_in       = age_ff;
      min_in       = min_ff;
      pend_vld_in  = pend_vld_ff;
      pend_key_in  = pend_key_ff;
      pend_age_in  = pend_age_ff;
      req_ch.ready = 1'b0;
      res_valid    = 1'b0;
      res          = '0;
      ram_wr       = '0;
      ram_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in       = req_ch.kind;
               key_in      = req_ch.game_key;
               age_in      = req_ch.age_value;
               min_in      = req_ch.min_age;
               idx_in      = '0;
               pend_vld_in = 1'b0;
               case (req_ch.kind)
                  KIND_INSERT: begin
                     if (fill_ff == FULL_COUNT) begin
                        status_in = STAT_FULL;
                        state_in  = S_RESULT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_REMOVE_KEY, KIND_FILTER: begin
                     state_in = S_SCAN;
                  end
                  KIND_REMOVE_LAST: begin
                     if (fill_ff == '0) begin
                        status_in = STAT_NOTFOUND;
                     end else begin
                        fill_in   = fill_ff - 1'b1;
                        status_in = STAT_REMOVED;
                     end
                     state_in = S_RESULT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_SCAN: begin
            if (!more) begin
               case (op_ff)
                  KIND_INSERT: begin
                     ram_wr.we   = 1'b1;
                     ram_wr.addr = fill_ff[ADDR_W-1:0];
                     ram_wr.data = {key_ff, age_ff};
                     fill_in     = fill_ff + 1'b1;
                     status_in   = STAT_ADDED;
                  end
                  KIND_REMOVE_KEY: status_in = STAT_NOTFOUND;
                  default: status_in = pend_vld_ff ? STAT_MATCH : STAT_NOMATCH;
               endcase
               state_in = S_RESULT;
            end else begin
               case (op_ff)
                  KIND_INSERT: begin
                     if (key_hit) begin
                        status_in = STAT_DUP;
                        state_in  = S_RESULT;
                     end else begin
                        idx_in    = idx_next;
                        ram_raddr = idx_next[ADDR_W-1:0];
                     end
                  end
                  KIND_REMOVE_KEY: begin
                     // step to the next entry; on the first match, start pulling later entries down
                     idx_in    = idx_next;
                     ram_raddr = idx_next[ADDR_W-1:0];
                     if (key_hit) begin
                        state_in = S_SHIFT;
                     end
                  end
                  KIND_FILTER: begin
                     if (age_hit && pend_vld_ff && !res_ready) begin
                        // hold: re-read the same entry until the held match drains
                        ram_raddr = idx_ff[ADDR_W-1:0];
                     end else begin
                        if (age_hit) begin
                           if (pend_vld_ff) begin
                              res_valid       = 1'b1;
                              res.status      = STAT_MATCH;
                              res.out_key     = pend_key_ff;
                              res.out_age     = pend_age_ff;
                              res.last_item   = 1'b0;
                              res.entry_total = fill_ff;
                           end
                           pend_vld_in = 1'b1;
                           pend_key_in = rd_key;
                           pend_age_in = rd_age;
                        end
                        idx_in    = idx_next;
                        ram_raddr = idx_next[ADDR_W-1:0];
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_SHIFT: begin
            if (!more) begin
               fill_in   = fill_ff - 1'b1;
               status_in = STAT_REMOVED;
               state_in  = S_RESULT;
            end else begin
               ram_wr.we   = 1'b1;
               ram_wr.addr = idx_prev[ADDR_W-1:0];
               ram_wr.data = ram_rdata;
               idx_in      = idx_next;
               ram_raddr   = idx_next[ADDR_W-1:0];
            end
         end

         S_RESULT: begin
            res_valid       = 1'b1;
            res.status      = status_ff;
            res.last_item   = 1'b1;
            res.entry_total = fill_ff;
            if (status_ff == STAT_MATCH) begin
               res.out_key = pend_key_ff;
               res.out_age = pend_age_ff;
            end
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end
endmodule

[hw/rtl/uktab_rsp_reg.sv]
// Output register stage of the response channel; parts the sequencer from the sink.
// Depends on uktab_pkg and uktab_if.
module uktab_rsp_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        res_valid,
   output logic                        res_ready,
   input  uktab_pkg::uktab_result_type res,
   uktab_rsp_if.source                 rsp_ch
);
   import uktab_pkg::*;

   logic             valid_ff, valid_in;
   uktab_result_type data_ff, data_in;
   logic             load;

   assign res_ready = !valid_ff || rsp_ch.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      data_in  = load ? res : data_ff;
      valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.status      = data_ff.status;
   assign rsp_ch.out_key     = data_ff.out_key;
   assign rsp_ch.out_age     = data_ff.out_age;
   assign rsp_ch.last_item   = data_ff.last_item;
   assign rsp_ch.entry_total = data_ff.entry_total;
endmodule

[hw/rtl/unique_key_sequential_table.sv]
// Unique key table: a packed list of up to DEPTH (64) entries, each a 16-bit key and an 8-bit
// age, kept in insertion order in one RAM with a registered read. One request transaction is
// taken at a time; req_ch.ready is high only while the sequencer is idle.
// Insert checks for a full table, then scans every held entry for a duplicate and appends.
// Remove by key scans to the first match and then shifts each later entry down one place,
// one entry per cycle. Remove last only lowers the fill count. Filter walks all held
// entries, one per cycle while the response sink does not stall a held match, and sends one
// response transaction per match with last_item on the final one (a single "no match"
// response when nothing qualifies). The single read port of the entry RAM sets this pace.
// A response register sits on the output, so the next request is taken while the last
// response still waits. The entry RAM needs no clearing after reset: only positions below
// the fill count are used.
`include "unique_key_sequential_table_assert.svh"

module unique_key_sequential_table (
   input  logic        clock,
   input  logic        reset,
   uktab_req_if.sink   req_ch,
   uktab_rsp_if.source rsp_ch
);
   import uktab_pkg::*;

   uktab_result_type         res;
   logic                     res_valid;
   logic                     res_ready;
   uktab_ram_wr_type         ram_wr;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [ENTRY_W-1:0]       ram_rdata;

   // Entry storage: {key, age} per position.
   uktab_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer: owns the fill count and walks the RAM for search, shift and filter.
   uktab_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_wr    (ram_wr),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // Output register: hold a finished response until the sink takes it.
   uktab_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_ch    (rsp_ch)
   );

   // Only a non-final filter match may leave last_item low.
   `UKTAB_ASSERT_SAME(a_last_only_match, clock, reset, rsp_ch.valid && !rsp_ch.last_item, rsp_ch.status == STAT_MATCH, "non-final response is not a match")
   // Key and age are zero on every response other than a match.
   `UKTAB_ASSERT_SAME(a_zero_payload, clock, reset, rsp_ch.valid && (rsp_ch.status != STAT_MATCH), (rsp_ch.out_key == '0) && (rsp_ch.out_age == '0), "payload not zero on non-match response")
   // The entry count never exceeds the table depth.
   `UKTAB_ASSERT_SAME(a_total_bound, clock, reset, rsp_ch.valid, rsp_ch.entry_total <= FULL_COUNT, "entry total beyond depth")
   // A request transaction makes the sequencer busy for at least the next cycle.
   `UKTAB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
endmodule

[tb/unique_key_sequential_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the unique key table: insert, remove, compaction and filter.
// Depends on uktab_pkg, uktab_if.sv and the unique_key_sequential_table RTL.
module unique_key_sequential_table_tb;
   import uktab_pkg::*;

   logic clock;
   logic reset;

   uktab_req_if req_ch ();
   uktab_rsp_if rsp_ch ();

   unique_key_sequential_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the table, updated when a request transaction is accepted.
   logic [KEY_W-1:0] tbl_key [DEPTH];
   logic [AGE_W-1:0] tbl_age [DEPTH];
   int               tbl_fill;

   // Responses still owed by the block, oldest first.
   uktab_result_type pending_rsp_q [$];
   uktab_result_type want_rsp;

   logic [KEY_W-1:0] key_pool [48];

   int error_count;
   int sent_count;
   int checked_count;
   int filter_count;
   int full_reject_count;
   int peak_fill;

   // Idle controls shared by the test tasks and the two handshake sides.
   bit req_idle_en;
   bit rsp_idle_en;
   bit rsp_hold_start;
   int rsp_hold_left;
   int rsp_gap_left;

   // 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("tb: %s mismatch at %0t ns: expected %0h, got %0h", what, $time, want, got);
      error_count++;
   endtask

   // Queue one expected response, entry_total taken from the shadow fill count.
   task automatic push_rsp(input uktab_status_type status, input logic [KEY_W-1:0] key,
                           input logic [AGE_W-1:0] age, input logic last);
      uktab_result_type r;
      r.status      = status;
      r.out_key     = key;
      r.out_age     = age;
      r.last_item   = last;
      r.entry_total = CNT_W'(tbl_fill);
      pending_rsp_q.push_back(r);
   endtask

   // Apply one accepted operation to the shadow table and queue what it must produce.
   task automatic apply_table_op(input uktab_kind_type kind, input logic [KEY_W-1:0] key,
                                 input logic [AGE_W-1:0] age,
                                 input logic [AGE_W-1:0] min_age);
      int pos;
      int hits;
      int seen;
      pos  = -1;
      hits = 0;
      seen = 0;
      case (kind)
         KIND_INSERT: begin
            // Full is checked before the duplicate search.
            if (tbl_fill >= DEPTH) begin
               full_reject_count++;
               push_rsp(STAT_FULL, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < tbl_fill; i++)
                  if (tbl_key[i] == key && pos < 0) pos = i;
               if (pos >= 0) begin
                  push_rsp(STAT_DUP, '0, '0, 1'b1);
               end else begin
                  tbl_key[tbl_fill] = key;
                  tbl_age[tbl_fill] = age;
                  tbl_fill++;
                  if (tbl_fill > peak_fill) peak_fill = tbl_fill;
                  push_rsp(STAT_ADDED, '0, '0, 1'b1);
               end
            end
         end
         KIND_REMOVE_KEY: begin
            for (int i = 0; i < tbl_fill; i++)
               if (tbl_key[i] == key && pos < 0) pos = i;
            if (pos < 0) begin
               push_rsp(STAT_NOTFOUND, '0, '0, 1'b1);
            end else begin
               // Close the gap: every later entry moves down one place.
               for (int i = pos; i + 1 < tbl_fill; i++) begin
                  tbl_key[i] = tbl_key[i+1];
                  tbl_age[i] = tbl_age[i+1];
               end
               tbl_fill--;
               push_rsp(STAT_REMOVED, '0, '0, 1'b1);
            end
         end
         KIND_REMOVE_LAST: begin
            if (tbl_fill == 0) begin
               push_rsp(STAT_NOTFOUND, '0, '0, 1'b1);
            end else begin
               tbl_fill--;
               push_rsp(STAT_REMOVED, '0, '0, 1'b1);
            end
         end
         default: begin
            filter_count++;
            for (int i = 0; i < tbl_fill; i++)
               if (tbl_age[i] >= min_age) hits++;
            if (hits == 0) begin
               push_rsp(STAT_NOMATCH, '0, '0, 1'b1);
            end else begin
               // Table order, last_item only on the final match.
               for (int i = 0; i < tbl_fill; i++) begin
                  if (tbl_age[i] >= min_age) begin
                     seen++;
                     push_rsp(STAT_MATCH, tbl_key[i], tbl_age[i], seen == hits);
                  end
               end
            end
         end
      endcase
   endtask

   // Offer one request transaction; hold it until the block takes it, then predict.
   task automatic send_op(input uktab_kind_type kind, input logic [KEY_W-1:0] key,
                          input logic [AGE_W-1:0] age, input logic [AGE_W-1:0] min_age);
      int gap;
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.game_key  <= key;
      req_ch.age_value <= age;
      req_ch.min_age   <= min_age;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
      apply_table_op(kind, key, age, min_age);
   endtask

   // Drop valid and hold off until the block has delivered everything owed.
   task automatic wait_for_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return key_pool[$urandom_range(0, 47)];
      if (r < 6 && tbl_fill > 0) return tbl_key[$urandom_range(0, tbl_fill - 1)];
      if (r == 6) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [AGE_W-1:0] pick_age();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return AGE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Short hand-picked sequence: empty table, extremes, duplicates, shifts, no-match.
   task automatic test_directed();
      send_op(KIND_REMOVE_LAST, 16'h0000, 8'h00, 8'h00);   // empty: not found
      send_op(KIND_REMOVE_KEY,  16'h0000, 8'h00, 8'h00);   // empty: not found
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'h00);   // empty: single no match
      send_op(KIND_INSERT,      16'h0000, 8'h00, 8'h00);
      send_op(KIND_INSERT,      16'hFFFF, 8'hFF, 8'h00);
      send_op(KIND_INSERT,      16'h0000, 8'h7F, 8'h00);   // duplicate key
      send_op(KIND_INSERT,      16'h8001, 8'h80, 8'h00);
      send_op(KIND_INSERT,      16'h7FFE, 8'h01, 8'h00);
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'h00);   // every entry matches
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'hFF);   // only the top age
      send_op(KIND_FILTER,      16'hFFFF, 8'hFF, 8'h80);
      send_op(KIND_REMOVE_KEY,  16'hFFFF, 8'h00, 8'h00);   // middle entry, shift down
      send_op(KIND_REMOVE_KEY,  16'h1234, 8'h00, 8'h00);   // absent key
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'h00);   // order after compaction
      send_op(KIND_REMOVE_LAST, 16'h0000, 8'h00, 8'h00);
      send_op(KIND_REMOVE_KEY,  16'h0000, 8'h00, 8'h00);   // first position
      send_op(KIND_REMOVE_KEY,  16'h8001, 8'h00, 8'h00);   // only entry left
      send_op(KIND_REMOVE_LAST, 16'h0000, 8'h00, 8'h00);   // empty again
      send_op(KIND_INSERT,      16'hAAAA, 8'h55, 8'h00);
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'h56);   // held entries, none match
      send_op(KIND_INSERT,      16'h5555, 8'hAA, 8'h00);
      send_op(KIND_FILTER,      16'h0000, 8'h00, 8'h55);
      send_op(KIND_REMOVE_KEY,  16'h5555, 8'h00, 8'h00);   // last position
   endtask

   // Fill the table to capacity, then hit every full-table path.
   task automatic test_full_table();
      logic [KEY_W-1:0] k;
      while (tbl_fill < DEPTH)
         send_op(KIND_INSERT, KEY_W'($urandom_range(0, 65535)), pick_age(), 8'h00);
      do k = KEY_W'($urandom_range(0, 65535)); while (pick_key() == k && 0);
      send_op(KIND_INSERT, k, pick_age(), 8'h00);                 // full
      send_op(KIND_INSERT, tbl_key[5], pick_age(), 8'h00);        // full wins over duplicate
      send_op(KIND_FILTER, 16'h0000, 8'h00, 8'h00);               // all 64 entries
      send_op(KIND_REMOVE_KEY, tbl_key[0], 8'h00, 8'h00);         // longest shift
      send_op(KIND_INSERT, 16'h0000, 8'h00, 8'h00);
      send_op(KIND_INSERT, 16'hFFFF, 8'hFF, 8'h00);
      send_op(KIND_REMOVE_KEY, tbl_key[tbl_fill - 1], 8'h00, 8'h00);
      send_op(KIND_FILTER, 16'h0000, 8'h00, pick_age());
      send_op(KIND_REMOVE_LAST, 16'h0000, 8'h00, 8'h00);
   endtask

   // Random operations; the mix leans toward removes as the table fills up.
   task automatic test_random_ops(input int count);
      int r;
      int ins_pct;
      uktab_kind_type kind;
      for (int n = 0; n < count; n++) begin
         ins_pct = (tbl_fill > 48) ? 20 : (tbl_fill < 8) ? 60 : 40;
         r = $urandom_range(0, 99);
         if (r < ins_pct)            kind = KIND_INSERT;
         else if (r < ins_pct + 25)  kind = KIND_REMOVE_KEY;
         else if (r < ins_pct + 35)  kind = KIND_REMOVE_LAST;
         else                        kind = KIND_FILTER;
         // Flip sender idling now and then so some stretches run back to back;
         // keep it off once the response side has stopped idling too.
         if (rsp_idle_en && n % 40 == 39) req_idle_en = ($urandom_range(0, 2) != 0);
         send_op(kind, pick_key(), pick_age(), pick_age());
      end
   endtask

   // Stall the response side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      rsp_hold_start = 1'b1;
      send_op(KIND_FILTER, 16'h0000, 8'h00, 8'h00);
      for (int n = 0; n < 15; n++)
         send_op(($urandom_range(0, 1) != 0) ? KIND_INSERT : KIND_FILTER,
                 pick_key(), pick_age(), pick_age());
   endtask

   // Sender goes quiet until every owed response has arrived, then resumes.
   task automatic test_drain_pause();
      wait_for_responses();
      send_op(KIND_FILTER, 16'h0000, 8'h00, pick_age());
      send_op(KIND_REMOVE_KEY, pick_key(), 8'h00, 8'h00);
      send_op(KIND_INSERT, pick_key(), pick_age(), 8'h00);
   endtask

   // Response side: random stall bursts, an optional long hold, or always ready.
   always @(negedge clock) begin
      if (rsp_hold_start) begin
         rsp_hold_left  = 300;
         rsp_hold_start = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_idle_en) begin
         rsp_ch.ready <= 1'b1;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_gap_left = $urandom_range(0, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check each response transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response, status", 0, rsp_ch.status);
         end else begin
            want_rsp = pending_rsp_q.pop_front();
            checked_count++;
            if (rsp_ch.status !== want_rsp.status)
               report_mismatch("status", want_rsp.status, rsp_ch.status);
            if (rsp_ch.out_key !== want_rsp.out_key)
               report_mismatch("out_key", want_rsp.out_key, rsp_ch.out_key);
            if (rsp_ch.out_age !== want_rsp.out_age)
               report_mismatch("out_age", want_rsp.out_age, rsp_ch.out_age);
            if (rsp_ch.last_item !== want_rsp.last_item)
               report_mismatch("last_item", want_rsp.last_item, rsp_ch.last_item);
            if (rsp_ch.entry_total !== want_rsp.entry_total)
               report_mismatch("entry_total", want_rsp.entry_total, rsp_ch.entry_total);
         end
      end
   end

   initial begin
      // Known values on every block input from time zero.
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_INSERT;
      req_ch.game_key  = '0;
      req_ch.age_value = '0;
      req_ch.min_age   = '0;
      rsp_ch.ready     = 1'b0;
      rsp_hold_start   = 1'b0;
      rsp_hold_left    = 0;
      rsp_gap_left     = 0;
      req_idle_en      = 1'b1;
      rsp_idle_en      = 1'b1;
      tbl_fill         = 0;
      peak_fill        = 0;
      error_count      = 0;
      sent_count       = 0;
      checked_count    = 0;
      filter_count     = 0;
      full_reject_count = 0;
      // Small pool of keys so duplicates and remove hits come up often.
      for (int i = 0; i < 48; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_random_ops(120);
      test_backpressure();
      test_drain_pause();
      // Final stretch: no idling on either side.
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      test_random_ops(60);

      // Let the block deliver the rest, then watch for stray responses.
      wait_for_responses();
      repeat (80) @(posedge clock);

      $display("tb: %0d request transactions, %0d responses checked, %0d errors",
               sent_count, checked_count, error_count);
      $display("tb: %0d filters, %0d full-table rejects, peak fill %0d of %0d",
               filter_count, full_reject_count, peak_fill, DEPTH);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
